@@ src/mwdds_pkg.sv @@
`timescale 1ns / 1ps

package mwdds_pkg;

    // default geometry
    localparam int DEFAULT_PHASE_BITS      = 32;
    localparam int DEFAULT_TABLE_ADDR_BITS = 10;
    localparam int DEFAULT_SAMPLE_BITS     = 16;

    // register file geometry
    localparam int SHAPE_BITS     = 2;
    localparam int STEP_BITS      = 32;
    localparam int GAIN_BITS      = 16;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_SHAPE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN       = 2'd2;

    // waveform codes
    localparam logic [SHAPE_BITS-1:0] SHAPE_SINE     = 2'd0;
    localparam logic [SHAPE_BITS-1:0] SHAPE_SQUARE   = 2'd1;
    localparam logic [SHAPE_BITS-1:0] SHAPE_TRIANGLE = 2'd2;
    localparam logic [SHAPE_BITS-1:0] SHAPE_SAWTOOTH = 2'd3;

    // register reset values
    localparam logic [SHAPE_BITS-1:0] RESET_WAVE_SHAPE = SHAPE_SINE;
    localparam logic [STEP_BITS-1:0]  RESET_PHASE_STEP = 32'd42852281;
    localparam logic [GAIN_BITS-1:0]  RESET_GAIN       = 16'd16384;

    // gain rounding: unsigned Q1.15
    localparam int GAIN_FRAC_BITS = 15;

    // odd polynomial for sin(pi/2 * u), all in Q30
    localparam longint unsigned SIN_C1 = 64'd1686629713;
    localparam longint unsigned SIN_C3 = 64'd693598668;
    localparam longint unsigned SIN_C5 = 64'd85569306;
    localparam longint unsigned SIN_C7 = 64'd5026994;
    localparam longint unsigned SIN_C9 = 64'd172272;
    localparam longint unsigned Q30    = 64'd1 << 30;

    typedef struct packed {
        logic [SHAPE_BITS-1:0] wave_shape;
        logic [GAIN_BITS-1:0]  gain;
    } cfg_t;

    // quarter-wave table entry, evaluated at elaboration only
    function automatic longint unsigned sine_entry(int idx, int tab_bits, int sample_bits);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned one;
        u   = 64'(idx) << (30 - (tab_bits - 2));
        u2  = (u * u) >> 30;
        t   = SIN_C9;
        t   = SIN_C7 - ((u2 * t) >> 30);
        t   = SIN_C5 - ((u2 * t) >> 30);
        t   = SIN_C3 - ((u2 * t) >> 30);
        t   = SIN_C1 - ((u2 * t) >> 30);
        s   = (u * t) >> 30;
        if (s > Q30) begin
            s = Q30;
        end
        one = 64'd1 << (sample_bits - 1);
        return (s * one + (Q30 >> 1)) >> 30;
    endfunction

endpackage

@@ src/mwdds_phase.sv @@
`timescale 1ns / 1ps

module mwdds_phase #(
    parameter int PHASE_BITS = mwdds_pkg::DEFAULT_PHASE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  restart,
    input  logic [PHASE_BITS-1:0] phase_step,
    output logic                  ph_valid,
    input  logic                  ph_ready,
    output logic [PHASE_BITS-1:0] ph_phase
);
    import mwdds_pkg::*;

    logic                  accept;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [PHASE_BITS-1:0] phase_out_reg;
    logic [PHASE_BITS-1:0] phase_out_next;
    logic                  valid_reg;
    logic                  valid_next;

    assign in_ready  = !valid_reg || ph_ready;
    assign accept    = in_valid && in_ready;
    assign phase_cur = restart ? '0 : phase_acc_reg;

    always_comb begin
        phase_acc_next = phase_acc_reg;
        phase_out_next = phase_out_reg;
        valid_next     = valid_reg && !ph_ready;
        if (accept) begin
            // modular add, wraps at 2^PHASE_BITS
            phase_acc_next = phase_cur + phase_step;
            phase_out_next = phase_cur;
            valid_next     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= '0;
            valid_reg     <= 1'b0;
        end else begin
            phase_acc_reg <= phase_acc_next;
            valid_reg     <= valid_next;
        end
        phase_out_reg <= phase_out_next;
    end

    assign ph_valid = valid_reg;
    assign ph_phase = phase_out_reg;

endmodule

@@ src/mwdds_wave.sv @@
`timescale 1ns / 1ps

module mwdds_wave #(
    parameter int PHASE_BITS      = mwdds_pkg::DEFAULT_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = mwdds_pkg::DEFAULT_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = mwdds_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [mwdds_pkg::SHAPE_BITS-1:0]     wave_shape,
    input  logic                                 ph_valid,
    output logic                                 ph_ready,
    input  logic [PHASE_BITS-1:0]                ph_phase,
    output logic                                 wv_valid,
    input  logic                                 wv_ready,
    output logic                                 wv_neg,
    output logic [SAMPLE_BITS-1:0]               wv_mag
);
    import mwdds_pkg::*;

    localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);
    localparam logic [SAMPLE_BITS-1:0] ONE     = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS:0]   TWO_ONE = (SAMPLE_BITS + 1)'(1) << SAMPLE_BITS;

    // quarter-wave magnitude table, QUARTER+1 entries
    logic [SAMPLE_BITS-1:0] sine_rom [0:QUARTER];

    for (genvar i = 0; i <= QUARTER; i++) begin : g_rom
        localparam logic [SAMPLE_BITS-1:0] ENTRY =
            SAMPLE_BITS'(sine_entry(i, TABLE_ADDR_BITS, SAMPLE_BITS));
        assign sine_rom[i] = ENTRY;
    end

    // phase scaled to n bits: top bits, zero-filled when the phase is narrower
    logic [PHASE_BITS+TABLE_ADDR_BITS-1:0] k_ext;
    logic [PHASE_BITS+SAMPLE_BITS-1:0]     saw_ext;
    logic [PHASE_BITS+SAMPLE_BITS:0]       tri_ext;
    logic [TABLE_ADDR_BITS-1:0]            k;
    logic [SAMPLE_BITS-1:0]                saw_top;
    logic [SAMPLE_BITS:0]                  tri_top;
    logic [1:0]                            quad;
    logic [TABLE_ADDR_BITS-3:0]            rem;
    logic [TABLE_ADDR_BITS-2:0]            q_idx;
    logic [SAMPLE_BITS:0]                  tri_dist;
    logic                                  neg_c;
    logic [SAMPLE_BITS-1:0]                mag_c;

    logic                   valid_reg;
    logic                   valid_next;
    logic                   neg_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;

    assign k_ext   = {ph_phase, {TABLE_ADDR_BITS{1'b0}}};
    assign saw_ext = {ph_phase, {SAMPLE_BITS{1'b0}}};
    assign tri_ext = {ph_phase, {(SAMPLE_BITS + 1){1'b0}}};
    assign k       = k_ext[PHASE_BITS+TABLE_ADDR_BITS-1 -: TABLE_ADDR_BITS];
    assign saw_top = saw_ext[PHASE_BITS+SAMPLE_BITS-1 -: SAMPLE_BITS];
    assign tri_top = tri_ext[PHASE_BITS+SAMPLE_BITS -: SAMPLE_BITS + 1];

    assign quad  = k[TABLE_ADDR_BITS-1 -: 2];
    assign rem   = k[TABLE_ADDR_BITS-3:0];
    // mirror the index in the falling quadrants
    assign q_idx = quad[0] ? ((TABLE_ADDR_BITS - 1)'(QUARTER) - {1'b0, rem})
                           : {1'b0, rem};

    // |t - 2^SAMPLE_BITS|, t below 2^(SAMPLE_BITS+1)
    assign tri_dist = tri_top[SAMPLE_BITS] ? {1'b0, tri_top[SAMPLE_BITS-1:0]}
                                           : (TWO_ONE - tri_top);

    always_comb begin
        neg_c = 1'b0;
        mag_c = '0;
        unique case (wave_shape)
            SHAPE_SINE: begin
                neg_c = quad[1];
                mag_c = sine_rom[q_idx];
            end
            SHAPE_SQUARE: begin
                neg_c = ph_phase[PHASE_BITS-1];
                mag_c = ONE;
            end
            SHAPE_TRIANGLE: begin
                if (tri_dist >= {1'b0, ONE}) begin
                    neg_c = 1'b0;
                    mag_c = SAMPLE_BITS'(tri_dist - {1'b0, ONE});
                end else begin
                    neg_c = 1'b1;
                    mag_c = SAMPLE_BITS'({1'b0, ONE} - tri_dist);
                end
            end
            SHAPE_SAWTOOTH: begin
                if (saw_top[SAMPLE_BITS-1]) begin
                    neg_c = 1'b0;
                    mag_c = {1'b0, saw_top[SAMPLE_BITS-2:0]};
                end else begin
                    neg_c = 1'b1;
                    mag_c = ONE - saw_top;
                end
            end
        endcase
    end

    assign ph_ready   = !valid_reg || wv_ready;
    assign valid_next = (ph_valid && ph_ready) || (valid_reg && !wv_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (ph_valid && ph_ready) begin
            neg_reg <= neg_c;
            mag_reg <= mag_c;
        end
    end

    assign wv_valid = valid_reg;
    assign wv_neg   = neg_reg;
    assign wv_mag   = mag_reg;

endmodule

@@ src/mwdds_scale.sv @@
`timescale 1ns / 1ps

module mwdds_scale #(
    parameter int SAMPLE_BITS = mwdds_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [mwdds_pkg::GAIN_BITS-1:0]   gain,
    input  logic                              wv_valid,
    output logic                              wv_ready,
    input  logic                              wv_neg,
    input  logic [SAMPLE_BITS-1:0]            wv_mag,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [SAMPLE_BITS-1:0]            out_sample
);
    import mwdds_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
    localparam logic [SAMPLE_BITS-1:0] MAX_MAG =
        (SAMPLE_BITS'(1) << (SAMPLE_BITS - 1)) - SAMPLE_BITS'(1);
    localparam logic [PROD_BITS:0] HALF_LSB = (PROD_BITS + 1)'(1) << (GAIN_FRAC_BITS - 1);

    logic [PROD_BITS-1:0]                prod;
    logic [PROD_BITS:0]                  rounded;
    logic [PROD_BITS-GAIN_FRAC_BITS:0]   scaled;
    logic [SAMPLE_BITS-1:0]              mag_sat;
    logic [SAMPLE_BITS-1:0]              sample_c;

    logic                   valid_reg;
    logic                   valid_next;
    logic [SAMPLE_BITS-1:0] sample_reg;

    assign prod    = PROD_BITS'(wv_mag) * PROD_BITS'(gain);
    // round half away from zero on the magnitude
    assign rounded = {1'b0, prod} + HALF_LSB;
    assign scaled  = rounded[PROD_BITS:GAIN_FRAC_BITS];
    assign mag_sat = (scaled > (PROD_BITS - GAIN_FRAC_BITS + 1)'(MAX_MAG))
                   ? MAX_MAG : SAMPLE_BITS'(scaled);
    assign sample_c = wv_neg ? (SAMPLE_BITS'(0) - mag_sat) : mag_sat;

    assign wv_ready   = !valid_reg || out_ready;
    assign valid_next = (wv_valid && wv_ready) || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (wv_valid && wv_ready) begin
            sample_reg <= sample_c;
        end
    end

    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;

endmodule

@@ src/multi_waveform_dds_unit.sv @@
`timescale 1ns / 1ps

// Phase-accumulator waveform generator. Every accepted input item yields
// exactly one output item carrying a signed sample. The item's restart bit
// clears the phase before its sample is taken; afterwards the phase advances
// by phase_step modulo 2^PHASE_BITS. The shape (sine from a quarter-wave
// table on the top TABLE_ADDR_BITS phase bits, square, triangle, sawtooth)
// is scaled by an unsigned Q1.15 gain, rounded half away from zero and
// saturated to +/-(2^(SAMPLE_BITS-1)-1). The datapath is three registered
// steps (phase, waveform lookup, gain multiply), so the block takes one item
// per clock unless m_tready holds it, and a sample passes the phase, waveform
// and output registers before it reaches m_tdata; the phase add is the only
// loop. Each step has its own valid and stalls only when the step after it is
// full, so items keep flowing into empty slots while a finished sample waits
// for m_tready. Configuration writes must be made while no item is in flight.

module multi_waveform_dds_unit #(
    parameter int PHASE_BITS      = mwdds_pkg::DEFAULT_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = mwdds_pkg::DEFAULT_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = mwdds_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [mwdds_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mwdds_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // [0] restart
    // output items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_tdata   // [SAMPLE_BITS-1:0] sample
);
    import mwdds_pkg::*;

    localparam int M_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int STEP_EXT     = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;
    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    // register file
    logic [SHAPE_BITS-1:0] wave_shape_reg;
    logic [SHAPE_BITS-1:0] wave_shape_next;
    logic [STEP_BITS-1:0]  phase_step_reg;
    logic [STEP_BITS-1:0]  phase_step_next;
    logic [GAIN_BITS-1:0]  gain_reg;
    logic [GAIN_BITS-1:0]  gain_next;
    cfg_t                  cfg;

    // step reduced (or widened) to the phase width
    logic [STEP_EXT-1:0]   step_ext;
    logic [PHASE_BITS-1:0] step_phase;

    // stage links
    logic                   ph_valid;
    logic                   ph_ready;
    logic [PHASE_BITS-1:0]  ph_phase;
    logic                   wv_valid;
    logic                   wv_ready;
    logic                   wv_neg;
    logic [SAMPLE_BITS-1:0] wv_mag;
    logic [SAMPLE_BITS-1:0] sample;

    always_comb begin
        wave_shape_next = wave_shape_reg;
        phase_step_next = phase_step_reg;
        gain_next       = gain_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WAVE_SHAPE: wave_shape_next = cfg_wdata[SHAPE_BITS-1:0];
                REG_PHASE_STEP: phase_step_next = cfg_wdata[STEP_BITS-1:0];
                REG_GAIN:       gain_next       = cfg_wdata[GAIN_BITS-1:0];
                default: begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_shape_reg <= RESET_WAVE_SHAPE;
            phase_step_reg <= RESET_PHASE_STEP;
            gain_reg       <= RESET_GAIN;
        end else begin
            wave_shape_reg <= wave_shape_next;
            phase_step_reg <= phase_step_next;
            gain_reg       <= gain_next;
        end
    end

    assign cfg.wave_shape = wave_shape_reg;
    assign cfg.gain       = gain_reg;

    assign step_ext   = STEP_EXT'(phase_step_reg);
    assign step_phase = step_ext[PHASE_BITS-1:0];

    // step 1: phase accumulator and phase register
    mwdds_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .restart    (s_tdata[0]),
        .phase_step (step_phase),
        .ph_valid   (ph_valid),
        .ph_ready   (ph_ready),
        .ph_phase   (ph_phase)
    );

    // step 2: waveform as sign and magnitude
    mwdds_wave #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_wave (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wave_shape (cfg.wave_shape),
        .ph_valid   (ph_valid),
        .ph_ready   (ph_ready),
        .ph_phase   (ph_phase),
        .wv_valid   (wv_valid),
        .wv_ready   (wv_ready),
        .wv_neg     (wv_neg),
        .wv_mag     (wv_mag)
    );

    // step 3: gain, rounding, saturation, output register
    mwdds_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .gain       (cfg.gain),
        .wv_valid   (wv_valid),
        .wv_ready   (wv_ready),
        .wv_neg     (wv_neg),
        .wv_mag     (wv_mag),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (sample)
    );

    // sample in the low bits, zero padding above
    assign m_tdata = M_TDATA_BITS'(sample);

    // saturation never lets the most negative code out
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (sample != MOST_NEG))
        else $error("sample reached the most negative code");

    // input stalls only when every step is full and the output is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (ph_valid && wv_valid && m_tvalid && !m_tready))
        else $error("input stalled with an empty pipeline slot");

    // a restart item always samples phase zero: with sine shape that is zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ph_valid && ph_ready && (ph_phase == '0) && (cfg.wave_shape == SHAPE_SINE))
        |=> (!wv_neg && (wv_mag == '0)))
        else $error("sine at phase zero is not zero");

endmodule
